/* rtl/core/scba_pkg.sv */
`default_nettype none

package scba_pkg;

    localparam int NUM_CLASSES     = 4;
    localparam int SLOTS_PER_CLASS = 64;
    localparam int TOTAL_SLOTS     = NUM_CLASSES * SLOTS_PER_CLASS;
    localparam int CLS_W           = $clog2(NUM_CLASSES);
    localparam int IDX_W           = (SLOTS_PER_CLASS > 1) ? $clog2(SLOTS_PER_CLASS) : 1;
    localparam int CNT_W           = IDX_W + 1;
    localparam int SLOT_W          = $clog2(TOTAL_SLOTS);
    localparam int ADDR_W          = 16;
    localparam int SIZE_W          = 8;
    localparam int POOL_W          = 17;
    localparam int BS_W            = 6;
    localparam int ENTRY_W         = ADDR_W + 1;

    localparam logic [POOL_W-1:0] POOL_LIMIT = POOL_W'(64'd1 << ADDR_W);
    localparam logic [CNT_W-1:0]  SLOTS_CNT  = CNT_W'(SLOTS_PER_CLASS);

    localparam logic KIND_REQ = 1'b0;
    localparam logic KIND_REL = 1'b1;

    localparam logic [BS_W-1:0] CLASS_SIZE [NUM_CLASSES] = '{6'd8, 6'd16, 6'd24, 6'd32};

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic             found;
        logic [CLS_W-1:0] cls;
    } t_class_sel;

    typedef struct packed {
        logic              in_use;
        logic [ADDR_W-1:0] addr;
    } t_slot;

    function automatic t_class_sel pick_class(input logic [SIZE_W-1:0] size);
        t_class_sel sel;
        sel = '0;
        for (int c = NUM_CLASSES - 1; c >= 0; c--) begin
            if (SIZE_W'(CLASS_SIZE[c]) > size) begin
                sel.found = 1'b1;
                sel.cls   = CLS_W'(c);
            end
        end
        return sel;
    endfunction

    function automatic logic [BS_W-1:0] class_size(input logic [CLS_W-1:0] cls);
        return CLASS_SIZE[cls];
    endfunction

    function automatic logic [SLOT_W-1:0] slot_of(input logic [CLS_W-1:0] cls,
                                                  input logic [IDX_W-1:0] idx);
        return SLOT_W'(SLOT_W'(cls) * SLOT_W'(SLOTS_PER_CLASS) + SLOT_W'(idx));
    endfunction

endpackage

`default_nettype wire

/* rtl/core/scba_ram.sv */
`default_nettype none

module scba_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 256
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

/* rtl/core/size_class_block_allocator.sv */
// Size-class block allocator with four classes of 8, 16, 24 and 32 byte blocks.
// Input stream: s_axis_tdata carries request_size and block_address, s_axis_tuser
// the kind (0 request, 1 release). Output stream: m_axis_tdata the granted
// address, m_axis_tuser the success flag. One result item per input item.
// An item is processed alone: s_axis_tready is high only while idle.
// Each class keeps a fill count of slots that already hold space; those form a
// prefix of the class. Both kinds walk that prefix through the slot RAM read
// port, one slot a cycle with the compare in the cycle after the read; a
// request that finds every filled slot in use takes the next slot from the pool
// at the end of the walk. Oversized sizes skip the walk. The result is valid the
// cycle after the walk (after acceptance for oversized sizes) and sits in the
// output register until m_axis_tready; a stalled receiver holds the block busy
// and blocks new input.
// i_cfg_we writes the pool size, reinitializing the pool and clearing every fill
// count; write it only while idle. Reset (i_rst_n low, synchronous) sets a
// 65536-byte pool with all slots free; slots beyond a fill count are treated as
// free, so no clearing pass is needed.
`default_nettype none

module size_class_block_allocator (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_we,
    input  wire logic [16:0] i_cfg_wdata,   // pool_bytes
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [23:0] s_axis_tdata,  // [7:0] request_size, [23:8] block_address
    input  wire logic        s_axis_tuser,  // [0] kind
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic      [15:0] m_axis_tdata,  // [15:0] granted_address
    output logic             m_axis_tuser   // [0] success
);

    scba_pkg::t_state r_state, n_state;

    logic                        r_kind;
    logic [scba_pkg::CLS_W-1:0]  r_cls;
    logic [scba_pkg::ADDR_W-1:0] r_addr;
    logic [scba_pkg::CNT_W-1:0]  r_idx;
    logic                        r_pend;
    logic [scba_pkg::IDX_W-1:0]  r_pidx;
    logic [scba_pkg::NUM_CLASSES-1:0][scba_pkg::CNT_W-1:0] r_fill;
    logic [scba_pkg::ADDR_W-1:0] r_next_free;
    logic [scba_pkg::POOL_W-1:0] r_bytes_left;
    logic [scba_pkg::ADDR_W-1:0] r_out_addr;
    logic                        r_out_ok;

    logic                        accept;
    logic [scba_pkg::SIZE_W-1:0] in_size;
    scba_pkg::t_class_sel        in_sel;
    logic [scba_pkg::BS_W-1:0]   bs;
    logic [scba_pkg::CNT_W-1:0]  fill;
    logic [scba_pkg::SLOT_W-1:0] cur_slot;
    logic [scba_pkg::SLOT_W-1:0] p_slot;
    logic                        issue;
    logic                        found;
    logic                        fits;
    logic                        room;
    logic                        grow;

    logic                        ram_we;
    logic [scba_pkg::SLOT_W-1:0] ram_waddr;
    scba_pkg::t_slot             ram_wdata;
    logic [scba_pkg::SLOT_W-1:0] ram_raddr;
    scba_pkg::t_slot             ram_rdata;

    assign accept   = s_axis_tvalid && s_axis_tready;
    assign in_size  = s_axis_tdata[7:0];
    assign in_sel   = scba_pkg::pick_class(in_size);
    assign bs       = scba_pkg::class_size(r_cls);
    assign fill     = r_fill[r_cls];
    assign cur_slot = scba_pkg::slot_of(r_cls, r_idx[scba_pkg::IDX_W-1:0]);
    assign p_slot   = scba_pkg::slot_of(r_cls, r_pidx);
    assign issue    = r_idx < fill;
    assign found    = r_pend && ((r_kind == scba_pkg::KIND_REQ) ? !ram_rdata.in_use :
                                 (ram_rdata.in_use && (ram_rdata.addr == r_addr)));
    assign fits     = r_bytes_left >= scba_pkg::POOL_W'(bs);
    assign room     = r_idx < scba_pkg::SLOTS_CNT;
    assign grow     = (r_state == scba_pkg::ST_SCAN) && !found && !issue &&
                      (r_kind == scba_pkg::KIND_REQ) && room && fits;

    always_comb begin
        n_state = r_state;
        case (r_state)
            scba_pkg::ST_IDLE: begin
                if (accept) begin
                    if (!in_sel.found) begin
                        n_state = scba_pkg::ST_DONE;
                    end else begin
                        n_state = scba_pkg::ST_SCAN;
                    end
                end
            end
            scba_pkg::ST_SCAN: begin
                if (found || !issue) begin
                    n_state = scba_pkg::ST_DONE;
                end
            end
            scba_pkg::ST_DONE: begin
                if (m_axis_tready) begin
                    n_state = scba_pkg::ST_IDLE;
                end
            end
            default: n_state = scba_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        s_axis_tready    = r_state == scba_pkg::ST_IDLE;
        m_axis_tvalid    = r_state == scba_pkg::ST_DONE;
        m_axis_tdata     = r_out_addr;
        m_axis_tuser     = r_out_ok;
        ram_raddr        = cur_slot;
        ram_we           = (r_state == scba_pkg::ST_SCAN) && (found || grow);
        ram_waddr        = found ? p_slot : cur_slot;
        ram_wdata.in_use = found ? (r_kind == scba_pkg::KIND_REQ) : 1'b1;
        ram_wdata.addr   = found ? ram_rdata.addr : r_next_free;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= scba_pkg::ST_IDLE;
            r_fill       <= '0;
            r_next_free  <= '0;
            r_bytes_left <= scba_pkg::POOL_LIMIT;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                r_fill       <= '0;
                r_next_free  <= '0;
                r_bytes_left <= (i_cfg_wdata > scba_pkg::POOL_LIMIT) ?
                                scba_pkg::POOL_LIMIT : i_cfg_wdata;
            end else if (grow) begin
                r_fill[r_cls] <= r_idx + scba_pkg::CNT_W'(1);
                r_next_free   <= r_next_free + scba_pkg::ADDR_W'(bs);
                r_bytes_left  <= r_bytes_left - scba_pkg::POOL_W'(bs);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            scba_pkg::ST_IDLE: begin
                r_kind     <= s_axis_tuser;
                r_cls      <= in_sel.cls;
                r_addr     <= s_axis_tdata[23:8];
                r_idx      <= '0;
                r_pend     <= 1'b0;
                r_out_addr <= '0;
                r_out_ok   <= 1'b0;
            end
            scba_pkg::ST_SCAN: begin
                r_pend <= issue;
                r_pidx <= r_idx[scba_pkg::IDX_W-1:0];
                if (issue) begin
                    r_idx <= r_idx + scba_pkg::CNT_W'(1);
                end
                if (found) begin
                    r_out_ok <= 1'b1;
                    if (r_kind == scba_pkg::KIND_REQ) begin
                        r_out_addr <= ram_rdata.addr;
                    end
                end else if (grow) begin
                    r_out_addr <= r_next_free;
                    r_out_ok   <= 1'b1;
                end
            end
            default: ;
        endcase
    end

    scba_ram #(
        .WIDTH (scba_pkg::ENTRY_W),
        .DEPTH (scba_pkg::TOTAL_SLOTS)
    ) u_slot_addr (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

`ifndef SYNTHESIS
    a_fill_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill[r_cls] <= scba_pkg::SLOTS_CNT)
        else $error("fill count above class size");

    a_bytes_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_bytes_left <= scba_pkg::POOL_LIMIT)
        else $error("bytes left above pool limit");

    a_fail_zero_addr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tuser |-> m_axis_tdata == '0)
        else $error("failed item carries an address");

    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(s_axis_tready && m_axis_tvalid))
        else $error("input taken while result pending");
`endif

endmodule

`default_nettype wire
